/* rtl/gcp_pkg.sv */
// ----------------------------------------------------------------------------
// G-code line parser package
// Shared types, character codes, command kinds and error codes.
// ----------------------------------------------------------------------------
package gcp_pkg;

   // Character codes
   localparam logic [7:0] CHAR_G      = 8'h47;
   localparam logic [7:0] CHAR_M      = 8'h4D;
   localparam logic [7:0] CHAR_X      = 8'h58;
   localparam logic [7:0] CHAR_Y      = 8'h59;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_ONE    = 8'h31;
   localparam logic [7:0] CHAR_TWO    = 8'h32;
   localparam logic [7:0] CHAR_FOUR   = 8'h34;
   localparam logic [7:0] CHAR_EIGHT  = 8'h38;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_DOT    = 8'h2E;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_CR     = 8'h0D;

   // Command kinds
   localparam logic [2:0] KIND_HOME   = 3'd0;
   localparam logic [2:0] KIND_MOVE   = 3'd1;
   localparam logic [2:0] KIND_STATUS = 3'd2;
   localparam logic [2:0] KIND_PEN    = 3'd3;
   localparam logic [2:0] KIND_LASER  = 3'd4;

   // Error codes
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_UNKNOWN  = 2'd1;
   localparam logic [1:0] ERR_NODIGITS = 2'd2;
   localparam logic [1:0] ERR_OVERFLOW = 2'd3;

   // Limits for the decimal reader, as wide as its multiply-by-ten product
   localparam logic [35:0] LIMIT_POS = 36'h0_7FFF_FFFF;
   localparam logic [35:0] LIMIT_NEG = 36'h0_8000_0000;

   typedef enum logic [3:0] {
      CS_START,
      CS_G,
      CS_G2,
      CS_M,
      CS_M1,
      CS_HOME,
      CS_MOVE,
      CS_STATUS,
      CS_PEN,
      CS_LASER,
      CS_BAD
   } cmd_state_type;

   typedef enum logic [2:0] {
      MP_SEEK_X,
      MP_GATHER_X,
      MP_SEEK_Y,
      MP_GATHER_Y,
      MP_DONE
   } move_phase_type;

   typedef enum logic [2:0] {
      NS_WS,
      NS_SIGN,
      NS_DIG,
      NS_DONE,
      NS_NONE,
      NS_OVF
   } num_status_type;

   typedef struct packed {
      num_status_type status;
      logic           negative;
      logic [31:0]    magnitude;
   } num_type;

   localparam num_type NUM_CLEAR = '{status: NS_WS, negative: 1'b0, magnitude: 32'd0};

   typedef struct packed {
      logic [7:0] char_byte;
      logic       line_end;
   } item_type;

   typedef struct packed {
      logic [2:0]  command_kind;
      logic [31:0] x_target;
      logic [31:0] y_target;
      logic [31:0] set_value;
      logic [1:0]  error_code;
   } result_type;

endpackage

/* rtl/gcp_channel_if.sv */
// ----------------------------------------------------------------------------
// G-code line parser channels
// Valid/ready channels for input characters and decoded commands.
// ----------------------------------------------------------------------------
interface gcp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       line_end;

   modport source (output valid, output char_byte, output line_end, input ready);
   modport sink (input valid, input char_byte, input line_end, output ready);
endinterface

interface gcp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  command_kind;
   logic [31:0] x_target;
   logic [31:0] y_target;
   logic [31:0] set_value;
   logic [1:0]  error_code;

   modport source (output valid, output command_kind, output x_target, output y_target,
                   output set_value, output error_code, input ready);
   modport sink (input valid, input command_kind, input x_target, input y_target,
                 input set_value, input error_code, output ready);
endinterface

/* rtl/gcode_line_parser.sv */
// ----------------------------------------------------------------------------
// G-code line parser
// Decodes one command per line from a stream of ASCII characters.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle while the result register can take each
// line's last character; characters pass once through the decoder's prefix
// match and multiply-by-ten accumulate. A command is loaded into the result
// register when its line's last character is decoded from the input register.
// Reset: synchronous; clears all line state and the valid flags of both register stages.
module gcode_line_parser
   import gcp_pkg::*;
(
   input logic      clock,
   input logic      reset,
   gcp_req_if.sink  req_chan,
   gcp_rsp_if.source rsp_chan
);

   item_type   in_item;
   item_type   dec_item;
   logic       dec_valid;
   logic       dec_take;
   logic       res_load;
   logic       res_ready;
   result_type dec_res;
   result_type out_res;

   assign in_item.char_byte = req_chan.char_byte;
   assign in_item.line_end  = req_chan.line_end;

   gcp_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_item   (in_item),
      .in_ready  (req_chan.ready),
      .out_valid (dec_valid),
      .out_item  (dec_item),
      .out_take  (dec_take)
   );

   gcp_line_decoder u_decoder (
      .clock      (clock),
      .reset      (reset),
      .item_valid (dec_valid),
      .item       (dec_item),
      .item_take  (dec_take),
      .res_ready  (res_ready),
      .res_load   (res_load),
      .res        (dec_res)
   );

   gcp_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (res_load),
      .load_data  (dec_res),
      .load_ready (res_ready),
      .out_valid  (rsp_chan.valid),
      .out_data   (out_res),
      .out_ready  (rsp_chan.ready)
   );

   assign rsp_chan.command_kind = out_res.command_kind;
   assign rsp_chan.x_target     = out_res.x_target;
   assign rsp_chan.y_target     = out_res.y_target;
   assign rsp_chan.set_value    = out_res.set_value;
   assign rsp_chan.error_code   = out_res.error_code;

endmodule

/* rtl/gcp_in_reg.sv */
// ----------------------------------------------------------------------------
// G-code line parser input register
// Holds one character item until the decoder takes it.
// ----------------------------------------------------------------------------
module gcp_in_reg
   import gcp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  item_type in_item,
   output logic     in_ready,
   output logic     out_valid,
   output item_type out_item,
   input  logic     out_take
);

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   assign in_ready  = !valid_ff || out_take;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= in_item;
      end
   end

endmodule

/* rtl/gcp_line_decoder.sv */
// ----------------------------------------------------------------------------
// G-code line decoder
// Matches the command prefix, reads numbers and builds one result per line.
// ----------------------------------------------------------------------------
module gcp_line_decoder
   import gcp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       item_valid,
   input  item_type   item,
   output logic       item_take,
   input  logic       res_ready,
   output logic       res_load,
   output result_type res
);

   cmd_state_type  cmd_state_ff, cmd_state_in;
   move_phase_type move_phase_ff, move_phase_in;
   num_type        num_ff, num_in;
   logic [31:0]    saved_x_ff, saved_x_in;
   logic [31:0]    saved_y_ff, saved_y_in;
   logic [1:0]     pending_error_ff, pending_error_in;

   typedef struct packed {
      logic [1:0]  err;
      logic [31:0] value;
   } finish_type;

   num_type    num_fed;
   finish_type fin_gather;
   finish_type fin_end;
   logic [7:0] c;

   // One character through the decimal reader: skip white space, optional sign, digits.
   function automatic num_type num_feed(num_type cur, logic [7:0] ch);
      num_type     nxt;
      logic        dig;
      logic        blank;
      logic [35:0] prod;
      logic [35:0] limit;
      logic        take_digit;
      nxt        = cur;
      dig        = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
      blank      = (ch == CHAR_SPACE) || ((ch >= CHAR_TAB) && (ch <= CHAR_CR));
      prod       = ({4'd0, cur.magnitude} << 3) + ({4'd0, cur.magnitude} << 1)
                   + {32'd0, ch[3:0]};
      limit      = cur.negative ? LIMIT_NEG : LIMIT_POS;
      take_digit = 1'b0;
      case (cur.status)
         NS_WS: begin
            if (blank) begin
               nxt.status = NS_WS;
            end else if (ch == CHAR_PLUS) begin
               nxt.status = NS_SIGN;
            end else if (ch == CHAR_MINUS) begin
               nxt.negative = 1'b1;
               nxt.status   = NS_SIGN;
            end else if (dig) begin
               take_digit = 1'b1;
            end else begin
               nxt.status = NS_NONE;
            end
         end
         NS_SIGN: begin
            if (dig) begin
               take_digit = 1'b1;
            end else begin
               nxt.status = NS_NONE;
            end
         end
         NS_DIG: begin
            if (dig) begin
               take_digit = 1'b1;
            end else begin
               nxt.status = NS_DONE;
            end
         end
         default: begin
            nxt.status = cur.status;
         end
      endcase
      if (take_digit) begin
         if (prod > limit) begin
            nxt.status = NS_OVF;
         end else begin
            nxt.magnitude = prod[31:0];
            nxt.status    = NS_DIG;
         end
      end
      return nxt;
   endfunction

   function automatic finish_type num_finish(num_type cur);
      finish_type f;
      f.err   = ERR_NODIGITS;
      f.value = 32'd0;
      if (cur.status == NS_OVF) begin
         f.err = ERR_OVERFLOW;
      end else if ((cur.status == NS_DIG) || (cur.status == NS_DONE)) begin
         f.err   = ERR_NONE;
         f.value = cur.negative ? (32'd0 - cur.magnitude) : cur.magnitude;
      end
      return f;
   endfunction

   assign c          = item.char_byte;
   assign item_take  = item_valid && (!item.line_end || res_ready);
   assign res_load   = item_take && item.line_end;
   assign num_fed    = num_feed(num_ff, c);
   assign fin_gather = num_finish(num_ff);
   assign fin_end    = num_finish(num_in);

   always_comb begin
      cmd_state_in     = cmd_state_ff;
      move_phase_in    = move_phase_ff;
      num_in           = num_ff;
      saved_x_in       = saved_x_ff;
      saved_y_in       = saved_y_ff;
      pending_error_in = pending_error_ff;
      case (cmd_state_ff)
         CS_START: begin
            if (c == CHAR_G) begin
               cmd_state_in = CS_G;
            end else if (c == CHAR_M) begin
               cmd_state_in = CS_M;
            end else begin
               cmd_state_in = CS_BAD;
            end
         end
         CS_G: begin
            if (c == CHAR_TWO) begin
               cmd_state_in = CS_G2;
            end else if (c == CHAR_ONE) begin
               cmd_state_in = CS_MOVE;
            end else begin
               cmd_state_in = CS_BAD;
            end
         end
         CS_G2: begin
            cmd_state_in = (c == CHAR_EIGHT) ? CS_HOME : CS_BAD;
         end
         CS_M: begin
            if (c == CHAR_ONE) begin
               cmd_state_in = CS_M1;
            end else if (c == CHAR_FOUR) begin
               cmd_state_in = CS_LASER;
            end else begin
               cmd_state_in = CS_BAD;
            end
         end
         CS_M1: begin
            // Anything other than a zero after M1 is already the pen value.
            if (c == CHAR_ZERO) begin
               cmd_state_in = CS_STATUS;
            end else begin
               cmd_state_in = CS_PEN;
               num_in       = num_fed;
            end
         end
         CS_MOVE: begin
            case (move_phase_ff)
               MP_SEEK_X: begin
                  if (c == CHAR_X) begin
                     move_phase_in = MP_GATHER_X;
                  end
               end
               MP_GATHER_X, MP_GATHER_Y: begin
                  if (c == CHAR_SPACE) begin
                     if (fin_gather.err != ERR_NONE) begin
                        pending_error_in = fin_gather.err;
                        move_phase_in    = MP_DONE;
                     end else if (move_phase_ff == MP_GATHER_X) begin
                        saved_x_in    = fin_gather.value;
                        move_phase_in = MP_SEEK_Y;
                     end else begin
                        saved_y_in    = fin_gather.value;
                        move_phase_in = MP_DONE;
                     end
                     num_in = NUM_CLEAR;
                  end else if (c != CHAR_DOT) begin
                     num_in = num_fed;
                  end
               end
               MP_SEEK_Y: begin
                  if (c == CHAR_Y) begin
                     move_phase_in = MP_GATHER_Y;
                  end
               end
               default: begin
                  move_phase_in = move_phase_ff;
               end
            endcase
         end
         CS_PEN, CS_LASER: begin
            num_in = num_fed;
         end
         default: begin
            cmd_state_in = cmd_state_ff;
         end
      endcase
   end

   // The result reflects the state after this line's final character.
   always_comb begin
      res.command_kind = KIND_HOME;
      res.x_target     = 32'd0;
      res.y_target     = 32'd0;
      res.set_value    = 32'd0;
      res.error_code   = ERR_NONE;
      case (cmd_state_in)
         CS_HOME: begin
            res.command_kind = KIND_HOME;
         end
         CS_STATUS: begin
            res.command_kind = KIND_STATUS;
         end
         CS_MOVE: begin
            res.command_kind = KIND_MOVE;
            res.error_code   = pending_error_in;
            if (pending_error_in == ERR_NONE) begin
               res.x_target = saved_x_in;
               res.y_target = saved_y_in;
            end
         end
         CS_PEN, CS_M1: begin
            res.command_kind = KIND_PEN;
            res.error_code   = fin_end.err;
            res.set_value    = fin_end.value;
         end
         CS_LASER: begin
            res.command_kind = KIND_LASER;
            res.error_code   = fin_end.err;
            res.set_value    = fin_end.value;
         end
         default: begin
            res.command_kind = KIND_HOME;
            res.error_code   = ERR_UNKNOWN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset || res_load) begin
         cmd_state_ff     <= CS_START;
         move_phase_ff    <= MP_SEEK_X;
         num_ff           <= NUM_CLEAR;
         saved_x_ff       <= 32'd0;
         saved_y_ff       <= 32'd0;
         pending_error_ff <= ERR_NONE;
      end else if (item_take) begin
         cmd_state_ff     <= cmd_state_in;
         move_phase_ff    <= move_phase_in;
         num_ff           <= num_in;
         saved_x_ff       <= saved_x_in;
         saved_y_ff       <= saved_y_in;
         pending_error_ff <= pending_error_in;
      end
   end

   a_line_end_restarts: assert property (@(posedge clock) disable iff (reset)
      res_load |=> (cmd_state_ff == CS_START) && (move_phase_ff == MP_SEEK_X))
      else $error("decoder state not cleared after line end");

   a_phase_only_in_move: assert property (@(posedge clock)
      (move_phase_ff != MP_SEEK_X) |-> (cmd_state_ff == CS_MOVE))
      else $error("move phase advanced outside a move command");

   a_error_ends_move: assert property (@(posedge clock)
      (pending_error_ff != ERR_NONE) |-> (move_phase_ff == MP_DONE))
      else $error("move error recorded without ending the move");

   a_unknown_has_no_data: assert property (@(posedge clock) disable iff (reset)
      (res_load && (res.error_code == ERR_UNKNOWN)) |->
      ((res.command_kind == KIND_HOME) && (res.x_target == 32'd0)
       && (res.y_target == 32'd0) && (res.set_value == 32'd0)))
      else $error("unknown command carries data");

endmodule

/* rtl/gcp_out_reg.sv */
// ----------------------------------------------------------------------------
// G-code line parser result register
// Holds one decoded command until the consumer takes it.
// ----------------------------------------------------------------------------
module gcp_out_reg
   import gcp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type load_data,
   output logic       load_ready,
   output logic       out_valid,
   output result_type out_data,
   input  logic       out_ready
);

   logic       valid_ff;
   logic       valid_in;
   result_type data_ff;

   assign load_ready = !valid_ff || out_ready;
   assign out_valid  = valid_ff;
   assign out_data   = data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

endmodule

/* dv/gcode_line_parser_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// G-code line parser testbench
// Streams directed and random command lines into the parser one character per
// item. A predictor decodes every accepted character alongside the parser and
// queues the command it expects at the end of each line. A checker compares
// each decoded command, field by field, with the oldest queued command.
// ----------------------------------------------------------------------------
module gcode_line_parser_test;
   import gcp_pkg::*;

   logic clock;
   logic reset;

   gcp_req_if req_chan ();
   gcp_rsp_if rsp_chan ();

   gcode_line_parser dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Predicted decoder state for the line in progress.
   cmd_state_type  line_cmd;
   move_phase_type line_phase;
   num_type        line_number;
   logic [31:0]    line_x;
   logic [31:0]    line_y;
   logic [1:0]     line_error;

   result_type     pending_commands[$];
   logic [7:0]     line_buf[$];
   int             mismatch_count   = 0;
   int             chars_sent       = 0;
   bit             sender_idles     = 1'b0;
   bit             receiver_idles   = 1'b0;
   int             hold_cycles_left = 0;
   string          filler_chars     = " FZ1.";
   string          prefix_chars     = "GM12480X";

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------
   function automatic num_type accumulate_digit(num_type n, logic [7:0] c);
      logic [35:0] limit;
      logic [35:0] product;
      limit   = n.negative ? LIMIT_NEG : LIMIT_POS;
      product = 36'(n.magnitude) * 36'd10 + 36'(c - CHAR_ZERO);
      if (product > limit) begin
         n.status = NS_OVF;
      end else begin
         n.magnitude = product[31:0];
         n.status    = NS_DIG;
      end
      return n;
   endfunction

   function automatic num_type read_number_char(num_type n, logic [7:0] c);
      logic is_digit;
      is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      case (n.status)
         NS_WS: begin
            if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR)) begin
               n.status = NS_WS;
            end else if (c == CHAR_PLUS) begin
               n.status = NS_SIGN;
            end else if (c == CHAR_MINUS) begin
               n.negative = 1'b1;
               n.status   = NS_SIGN;
            end else if (is_digit) begin
               n = accumulate_digit(n, c);
            end else begin
               n.status = NS_NONE;
            end
         end
         NS_SIGN: begin
            if (is_digit) n = accumulate_digit(n, c);
            else n.status = NS_NONE;
         end
         NS_DIG: begin
            if (is_digit) n = accumulate_digit(n, c);
            else n.status = NS_DONE;
         end
         default: ;
      endcase
      return n;
   endfunction

   function automatic logic [1:0] number_error(num_type n);
      if (n.status == NS_OVF) return ERR_OVERFLOW;
      if (n.status == NS_DIG || n.status == NS_DONE) return ERR_NONE;
      return ERR_NODIGITS;
   endfunction

   function automatic logic [31:0] number_value(num_type n);
      return n.negative ? -n.magnitude : n.magnitude;
   endfunction

   task automatic clear_line_state();
      line_cmd    = CS_START;
      line_phase  = MP_SEEK_X;
      line_number = NUM_CLEAR;
      line_x      = '0;
      line_y      = '0;
      line_error  = ERR_NONE;
   endtask

   task automatic decode_char(input logic [7:0] c, input logic last);
      result_type cmd;
      case (line_cmd)
         CS_START: begin
            if (c == CHAR_G) line_cmd = CS_G;
            else if (c == CHAR_M) line_cmd = CS_M;
            else line_cmd = CS_BAD;
         end
         CS_G: begin
            if (c == CHAR_TWO) line_cmd = CS_G2;
            else if (c == CHAR_ONE) line_cmd = CS_MOVE;
            else line_cmd = CS_BAD;
         end
         CS_G2: line_cmd = (c == CHAR_EIGHT) ? CS_HOME : CS_BAD;
         CS_M: begin
            if (c == CHAR_ONE) line_cmd = CS_M1;
            else if (c == CHAR_FOUR) line_cmd = CS_LASER;
            else line_cmd = CS_BAD;
         end
         CS_M1: begin
            if (c == CHAR_ZERO) begin
               line_cmd = CS_STATUS;
            end else begin
               // The character after M1 already belongs to the pen value.
               line_cmd    = CS_PEN;
               line_number = read_number_char(line_number, c);
            end
         end
         CS_MOVE: begin
            case (line_phase)
               MP_SEEK_X: if (c == CHAR_X) line_phase = MP_GATHER_X;
               MP_SEEK_Y: if (c == CHAR_Y) line_phase = MP_GATHER_Y;
               MP_GATHER_X, MP_GATHER_Y: begin
                  if (c == CHAR_SPACE) begin
                     if (number_error(line_number) != ERR_NONE) begin
                        line_error = number_error(line_number);
                        line_phase = MP_DONE;
                     end else if (line_phase == MP_GATHER_X) begin
                        line_x     = number_value(line_number);
                        line_phase = MP_SEEK_Y;
                     end else begin
                        line_y     = number_value(line_number);
                        line_phase = MP_DONE;
                     end
                     line_number = NUM_CLEAR;
                  end else if (c != CHAR_DOT) begin
                     line_number = read_number_char(line_number, c);
                  end
               end
               default: ;
            endcase
         end
         CS_PEN, CS_LASER: line_number = read_number_char(line_number, c);
         default: ;
      endcase

      if (last) begin
         cmd = '0;
         case (line_cmd)
            CS_HOME: cmd.command_kind = KIND_HOME;
            CS_STATUS: cmd.command_kind = KIND_STATUS;
            CS_MOVE: begin
               cmd.command_kind = KIND_MOVE;
               cmd.error_code   = line_error;
               if (line_error == ERR_NONE) begin
                  cmd.x_target = line_x;
                  cmd.y_target = line_y;
               end
            end
            CS_PEN, CS_M1, CS_LASER: begin
               cmd.command_kind = (line_cmd == CS_LASER) ? KIND_LASER : KIND_PEN;
               cmd.error_code   = number_error(line_number);
               if (cmd.error_code == ERR_NONE) cmd.set_value = number_value(line_number);
            end
            default: begin
               cmd.command_kind = KIND_HOME;
               cmd.error_code   = ERR_UNKNOWN;
            end
         endcase
         pending_commands.push_back(cmd);
         clear_line_state();
      end
   endtask

   // ---------------------------------------------------------------------
   // Checker: compares each decoded command, then feeds the predictor.
   // ---------------------------------------------------------------------
   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got, input bit is_signed);
      if (got !== want) begin
         if (is_signed) $error("%s: expected %0d, got %0d", field, $signed(want), $signed(got));
         else $error("%s: expected %0d, got %0d", field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_commands.size() == 0) begin
               $error("command with no line pending: kind %0d, error %0d",
                      rsp_chan.command_kind, rsp_chan.error_code);
               mismatch_count++;
            end else begin
               want = pending_commands.pop_front();
               check_field("command_kind", 32'(want.command_kind),
                           32'(rsp_chan.command_kind), 1'b0);
               check_field("x_target", want.x_target, rsp_chan.x_target, 1'b1);
               check_field("y_target", want.y_target, rsp_chan.y_target, 1'b1);
               check_field("set_value", want.set_value, rsp_chan.set_value, 1'b1);
               check_field("error_code", 32'(want.error_code),
                           32'(rsp_chan.error_code), 1'b0);
            end
         end
         if (req_chan.valid && req_chan.ready) decode_char(req_chan.char_byte, req_chan.line_end);
      end
   end

   // Command receiver: random stalls, plus a long hold-off when one is requested.
   always @(negedge clock) begin
      if (hold_cycles_left > 0) begin
         rsp_chan.ready = 1'b0;
         hold_cycles_left--;
      end else if (receiver_idles) begin
         rsp_chan.ready = ($urandom_range(0, 99) >= 26);
      end else begin
         rsp_chan.ready = 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Character sender and line builders
   // ---------------------------------------------------------------------
   task automatic send_char(input logic [7:0] c, input logic last);
      while (sender_idles && $urandom_range(0, 99) < 26) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid     = 1'b1;
      req_chan.char_byte = c;
      req_chan.line_end  = last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
      chars_sent++;
   endtask

   task automatic send_line();
      foreach (line_buf[i]) send_char(line_buf[i], i == line_buf.size() - 1);
      line_buf.delete();
   endtask

   task automatic append_text(input string s);
      for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
   endtask

   task automatic send_text(input string s);
      append_text(s);
      send_line();
   endtask

   task automatic append_filler();
      int count;
      count = $urandom_range(0, 3);
      for (int i = 0; i < count; i++) line_buf.push_back(filler_chars[$urandom_range(0, 4)]);
   endtask

   // A decimal value; inside a move a space would end it, so only other
   // white space leads it there, and dots may fall between digits.
   task automatic append_number(input bit in_move);
      int digits;
      if ($urandom_range(0, 4) == 0) begin
         if (!in_move && $urandom_range(0, 1) == 0) line_buf.push_back(CHAR_SPACE);
         else line_buf.push_back(8'($urandom_range(CHAR_TAB, CHAR_CR)));
      end
      case ($urandom_range(0, 3))
         2: line_buf.push_back(CHAR_PLUS);
         3: line_buf.push_back(CHAR_MINUS);
         default: ;
      endcase
      if ($urandom_range(0, 14) == 0) begin
         append_text($urandom_range(0, 1) ? "2147483647" : "2147483648");
      end else begin
         digits = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 11) : $urandom_range(0, 5);
         for (int i = 0; i < digits; i++) begin
            line_buf.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
            if (in_move && $urandom_range(0, 4) == 0) line_buf.push_back(CHAR_DOT);
         end
      end
      if ($urandom_range(0, 7) == 0) line_buf.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic build_random_line();
      int pick;
      int count;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         append_text("G28");
      end else if (pick < 45) begin
         append_text("G1");
         append_filler();
         if ($urandom_range(0, 11) != 0) append_text("X");
         append_number(1'b1);
         if ($urandom_range(0, 9) != 0) begin
            append_text(" ");
            append_filler();
            if ($urandom_range(0, 11) != 0) append_text("Y");
            append_number(1'b1);
            if ($urandom_range(0, 5) != 0) append_text(" ");
         end
      end else if (pick < 55) begin
         append_text("M10");
      end else if (pick < 70) begin
         append_text("M1");
         append_number(1'b0);
      end else if (pick < 85) begin
         append_text("M4");
         append_number(1'b0);
      end else if (pick < 93) begin
         count = $urandom_range(1, 6);
         for (int i = 0; i < count; i++) line_buf.push_back(8'($urandom_range(0, 255)));
      end else begin
         count = $urandom_range(1, 3);
         for (int i = 0; i < count; i++) line_buf.push_back(prefix_chars[$urandom_range(0, 7)]);
      end
      if ($urandom_range(0, 3) == 0) append_filler();
      // Now and then the line is cut short at a random point.
      if ($urandom_range(0, 9) == 0 && line_buf.size() > 1) begin
         count = $urandom_range(1, line_buf.size() - 1);
         while (line_buf.size() > count) void'(line_buf.pop_back());
      end
   endtask

   task automatic wait_for_commands();
      req_chan.valid = 1'b0;
      while (pending_commands.size() != 0) @(negedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   task automatic test_prefix_commands();
      send_text("G28");
      send_text("G28 X5");
      send_text("M10");
      send_text("G");
      send_text("G2");
      send_text("M");
      send_text("G27");
      send_text("M7");
      send_text("X1");
      line_buf.push_back(8'hFF);
      send_line();
   endtask

   task automatic test_move_lines();
      send_text("G1 X10.50 Y-3.25 ");
      send_text("G1 X-21474836.48 Y21474836.47 ");
      send_text("G1 X1.5 Y2");
      send_text("G1 X12");
      send_text("G1 Y5 ");
      send_text("G1 X Y1 ");
      send_text("G1 X1 Y 3 ");
      send_text("G1 X99999999.99 Y1 ");
   endtask

   task automatic test_pen_and_laser_lines();
      send_text("M1");
      send_text("M1 255");
      send_text("M1-5");
      send_text("M4 -2147483648");
      send_text("M42147483648");
      send_text("M4 +");
      send_text("M1\t\015 7x");
      send_text("M4 2147483647 9");
   endtask

   task automatic test_random_lines(input int char_budget);
      int stop_at;
      stop_at = chars_sent + char_budget;
      while (chars_sent < stop_at) begin
         build_random_line();
         send_line();
      end
   endtask

   task automatic test_back_to_back_lines();
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      test_random_lines(100);
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
   endtask

   // The receiver stalls long enough for the parser to fill and stop
   // taking characters while lines keep coming.
   task automatic test_output_backpressure();
      hold_cycles_left = 300;
      for (int i = 0; i < 12; i++) begin
         build_random_line();
         send_line();
      end
      wait_for_commands();
   endtask

   initial begin
      req_chan.valid     = 1'b0;
      req_chan.char_byte = '0;
      req_chan.line_end  = 1'b0;
      rsp_chan.ready     = 1'b0;
      clear_line_state();
      reset = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;

      test_prefix_commands();
      test_move_lines();
      test_pen_and_laser_lines();
      wait_for_commands();
      test_back_to_back_lines();
      test_random_lines(180);
      wait_for_commands();
      test_output_backpressure();
      test_random_lines(80);

      wait_for_commands();
      repeat (10) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("gcode_line_parser_test: PASS");
      end else begin
         $display("gcode_line_parser_test: FAIL");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("gcode_line_parser_test: FAIL");
      $finish;
   end

endmodule
